// ===== rtl/core/euler_point_rotation_macros.svh =====
// ----------------------------------------------------------------------------
// Euler point rotation assertion macros
// Shared concurrent assertion shorthands, clocked on clk, quiet during rst.
// ----------------------------------------------------------------------------
`ifndef EULER_POINT_ROTATION_MACROS_SVH
`define EULER_POINT_ROTATION_MACROS_SVH

// Property must hold at every edge outside reset.
`define EPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define EPR_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/core/epr_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler point rotation package
// Widths, payload structs, register indexes and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int COORD_BITS      = 24;
  localparam int ANGLE_BITS      = 16;
  localparam int COLOUR_BITS     = 24;
  localparam int TRIG_BITS       = 17;  // Q1.15 plus room for +1.0
  localparam int TRIG_FRAC       = 15;
  localparam int AXES            = 3;
  localparam int AXIS_BITS       = 2;
  localparam int STAGES_PER_AXIS = 2;
  localparam int PIPE_DEPTH      = AXES * STAGES_PER_AXIS;
  localparam int PROD_BITS       = COORD_BITS + TRIG_BITS;
  localparam int SUM_BITS        = PROD_BITS + 1;
  localparam int QUOT_BITS       = SUM_BITS - TRIG_FRAC;

  // register indexes on the configuration port
  localparam logic [AXIS_BITS-1:0] REG_ANGLE_X = AXIS_BITS'(0);
  localparam logic [AXIS_BITS-1:0] REG_ANGLE_Y = AXIS_BITS'(1);
  localparam logic [AXIS_BITS-1:0] REG_ANGLE_Z = AXIS_BITS'(2);

  localparam logic signed [TRIG_BITS-1:0] TRIG_ONE  = TRIG_BITS'(2 ** TRIG_FRAC);
  localparam logic signed [TRIG_BITS-1:0] TRIG_ZERO = '0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic signed [COORD_BITS-1:0] in_z;
    logic        [COLOUR_BITS-1:0] in_colour;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic        [COLOUR_BITS-1:0] out_colour;
  } result_t;

  // cosine and sine of one axis
  typedef struct packed {
    logic signed [TRIG_BITS-1:0] cos_v;
    logic signed [TRIG_BITS-1:0] sin_v;
  } trig_t;

  // the coordinate an axis stage leaves alone, plus colour
  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord;
    logic        [COLOUR_BITS-1:0] colour;
  } side_t;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_RUN,
    TRIG_WRITE
  } trig_state_t;

  // sum already carries the rounding half; floor shift, then saturate
  function automatic logic signed [COORD_BITS-1:0] round_sat(
    input logic signed [SUM_BITS-1:0] sum
  );
    logic [QUOT_BITS-1:0] q;
    logic [QUOT_BITS-COORD_BITS:0] top;
    logic signed [COORD_BITS-1:0] r;
    q   = sum[SUM_BITS-1:TRIG_FRAC];
    top = q[QUOT_BITS-1:COORD_BITS-1];
    if (top == '0 || top == '1) begin
      r = q[COORD_BITS-1:0];
    end else if (q[QUOT_BITS-1]) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/epr_trig.sv =====
// ----------------------------------------------------------------------------
// Euler point rotation sine/cosine unit
// Angle register writes, iterative CORDIC (one step a cycle), Q1.15 storage.
// ----------------------------------------------------------------------------
module epr_trig
  import epr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [AXIS_BITS-1:0]          cfg_index,
  input  logic [ANGLE_BITS-1:0]         cfg_data,
  output logic                          busy,
  output trig_t [AXES-1:0]              trig
);

  localparam int TURN_BITS    = 32;
  localparam int CW           = TURN_BITS + 2;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(CORDIC_STEPS - 1);

  localparam logic signed [CW-1:0] GAIN    = CW'(652032874);
  localparam logic signed [CW-1:0] QUARTER = CW'(1) << (TURN_BITS - 2);
  localparam logic signed [CW-1:0] HALF    = CW'(1) << (TURN_BITS - 1);
  localparam logic signed [CW-1:0] RND     = CW'(1) << (TRIG_FRAC - 1);
  localparam logic signed [CW-TRIG_FRAC-1:0] Q_ONE = (CW - TRIG_FRAC)'(2 ** TRIG_FRAC);

  // arctangent of 2^-i, 2^32 units per turn
  localparam logic signed [CW-1:0] ATAN_LUT [CORDIC_STEPS] = '{
    CW'(536870912), CW'(316933406), CW'(167458907), CW'(85004756),
    CW'(42667331),  CW'(21354465),  CW'(10679838),  CW'(5340245),
    CW'(2670163),   CW'(1335087),   CW'(667544),    CW'(333772),
    CW'(166886),    CW'(83443),     CW'(41722),     CW'(20861),
    CW'(10430),     CW'(5215),      CW'(2608),      CW'(1304),
    CW'(652),       CW'(326),       CW'(163),       CW'(81)
  };

  trig_state_t state, state_next;

  logic                   start;
  logic [STEP_BITS-1:0]   step;
  logic [AXIS_BITS-1:0]   axis_sel;
  logic                   flip;
  logic signed [CW-1:0]   cx, cy, cz;
  logic signed [CW-1:0]   z_raw, z_init;
  logic                   flip_init;
  logic signed [CW-1:0]   dx, dy, at;

  function automatic logic signed [TRIG_BITS-1:0] to_q15(
    input logic signed [CW-1:0] v,
    input logic                 neg
  );
    logic signed [CW-1:0]           r;
    logic signed [CW-TRIG_FRAC-1:0] q;
    logic signed [TRIG_BITS-1:0]    c;
    r = v + RND;
    q = r[CW-1:TRIG_FRAC];
    if (q > Q_ONE) begin
      c = TRIG_ONE;
    end else if (q < -Q_ONE) begin
      c = -TRIG_ONE;
    end else begin
      c = q[TRIG_BITS-1:0];
    end
    return neg ? -c : c;
  endfunction

  assign start = cfg_valid && !busy &&
                 (cfg_index inside {REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z});

  // fold the angle into +-quarter turn
  always_comb begin
    z_raw = CW'($signed({cfg_data, {(TURN_BITS-ANGLE_BITS){1'b0}}}));
    if (z_raw > QUARTER) begin
      z_init    = z_raw - HALF;
      flip_init = 1'b1;
    end else if (z_raw < -QUARTER) begin
      z_init    = z_raw + HALF;
      flip_init = 1'b1;
    end else begin
      z_init    = z_raw;
      flip_init = 1'b0;
    end
  end

  always_comb begin
    dx = cy >>> step;
    dy = cx >>> step;
    at = ATAN_LUT[step];
  end

  always_comb begin : next_state_logic
    state_next = state;
    case (state)
      TRIG_IDLE:  if (start) state_next = TRIG_RUN;
      TRIG_RUN:   if (step == STEP_LAST) state_next = TRIG_WRITE;
      TRIG_WRITE: state_next = TRIG_IDLE;
      default:    state_next = TRIG_IDLE;
    endcase
  end

  always_comb begin : output_logic
    case (state)
      TRIG_IDLE: busy = 1'b0;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TRIG_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        step <= '0;
      end else if (state == TRIG_RUN) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx       <= GAIN;
      cy       <= '0;
      cz       <= z_init;
      flip     <= flip_init;
      axis_sel <= cfg_index;
    end else if (state == TRIG_RUN) begin
      if (!cz[CW-1]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        trig[i].cos_v <= TRIG_ONE;
        trig[i].sin_v <= TRIG_ZERO;
      end
    end else if (state == TRIG_WRITE) begin
      trig[axis_sel].cos_v <= to_q15(cx, flip);
      trig[axis_sel].sin_v <= to_q15(cy, flip);
    end
  end

endmodule

// ===== rtl/core/epr_axis.sv =====
// ----------------------------------------------------------------------------
// Euler point rotation axis stage
// Two-stage plane rotation: p' = p*c - q*s, q' = q*c + p*s, rounded, saturated.
// ----------------------------------------------------------------------------
module epr_axis
  import epr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_p,
  input  logic signed [COORD_BITS-1:0]  in_q,
  input  side_t                         in_side,
  input  trig_t                         trig,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_p,
  output logic signed [COORD_BITS-1:0]  out_q,
  output side_t                         out_side
);

  localparam logic signed [SUM_BITS-1:0] RND = SUM_BITS'(2 ** (TRIG_FRAC - 1));

  logic                         v1;
  logic                         en1, en2;
  logic signed [PROD_BITS-1:0]  pc, qs, qc, ps;
  side_t                        side1;

  // per-stage enables: a stage moves when empty or when the next one moves
  assign en2      = !out_valid || !out_stall;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en1) begin
      pc    <= PROD_BITS'(in_p) * PROD_BITS'(trig.cos_v);
      qs    <= PROD_BITS'(in_q) * PROD_BITS'(trig.sin_v);
      qc    <= PROD_BITS'(in_q) * PROD_BITS'(trig.cos_v);
      ps    <= PROD_BITS'(in_p) * PROD_BITS'(trig.sin_v);
      side1 <= in_side;
    end
  end

  // stage 2: sum, round, saturate
  always_ff @(posedge clk) begin
    if (en2) begin
      out_p    <= round_sat(SUM_BITS'(pc) - SUM_BITS'(qs) + RND);
      out_q    <= round_sat(SUM_BITS'(qc) + SUM_BITS'(ps) + RND);
      out_side <= side1;
    end
  end

endmodule

// ===== rtl/core/euler_point_rotation.sv =====
// ----------------------------------------------------------------------------
// Euler point rotation
// Rotates one vertex per cycle (when not stalled) about x, then y, then z by programmed angles.
// ----------------------------------------------------------------------------
// Usage:
//   vertex channel: a transaction moves when vertex_valid is high and
//     vertex_stall is low. Payload is x, y, z (signed Q15.8) and colour.
//   result channel: same rules, result_stall driven by the receiver.
//     Colour passes straight through; coordinates are rounded and
//     saturated after each axis.
//   cfg channel: cfg_index selects the x, y or z angle (binary angle, one
//     full turn = 2^16). A write launches a 24-step CORDIC that computes the
//     axis' cosine and sine; cfg_ready and vertex intake stay low until it is written.
//     Index 3 is accepted and ignored.
// Pipeline: two registers per axis (multiply, then sum/round/saturate)
//   between vertex accept and result valid.
// Throughput: one vertex per cycle with no stall; each axis stage is a
//   four-multiplier slice.
// Reset: synchronous rst empties the pipe and loads cos = 1.0, sin = 0.
// Stall: each stage holds while the one after it is full and stalled;
//   empty stages keep filling, so the pipe packs up before vertex_stall rises.
// ----------------------------------------------------------------------------
module euler_point_rotation
  import epr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   vertex_valid,
  output logic                   vertex_stall,
  input  vertex_t                vertex,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [AXIS_BITS-1:0]   cfg_index,
  input  logic [ANGLE_BITS-1:0]  cfg_data
);

  logic            busy;
  trig_t [AXES-1:0] trig;

  // axis x: p = y, q = z, side = x
  logic                          ax_valid, ax_stall, ax_in_stall;
  logic signed [COORD_BITS-1:0]  ax_p, ax_q;
  side_t                         ax_side, ax_in_side;
  // axis y: p = x, q = z, side = y
  logic                          ay_valid, ay_stall;
  logic signed [COORD_BITS-1:0]  ay_p, ay_q;
  side_t                         ay_side, ay_in_side;
  // axis z: p = y, q = x, side = z
  logic                          az_stall;
  logic signed [COORD_BITS-1:0]  az_p, az_q;
  side_t                         az_side, az_in_side;

  assign cfg_ready = !busy;

  epr_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .trig      (trig)
  );

  // intake closes while the angle unit is running
  assign vertex_stall = busy || ax_in_stall;

  assign ax_in_side = '{coord: vertex.in_x, colour: vertex.in_colour};

  epr_axis u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex_valid && !busy),
    .in_stall  (ax_in_stall),
    .in_p      (vertex.in_y),
    .in_q      (vertex.in_z),
    .in_side   (ax_in_side),
    .trig      (trig[REG_ANGLE_X]),
    .out_valid (ax_valid),
    .out_stall (ax_stall),
    .out_p     (ax_p),
    .out_q     (ax_q),
    .out_side  (ax_side)
  );

  assign ay_in_side = '{coord: ax_p, colour: ax_side.colour};

  epr_axis u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ax_valid),
    .in_stall  (ax_stall),
    .in_p      (ax_side.coord),
    .in_q      (ax_q),
    .in_side   (ay_in_side),
    .trig      (trig[REG_ANGLE_Y]),
    .out_valid (ay_valid),
    .out_stall (ay_stall),
    .out_p     (ay_p),
    .out_q     (ay_q),
    .out_side  (ay_side)
  );

  assign az_in_side = '{coord: ay_q, colour: ay_side.colour};

  epr_axis u_axis_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ay_valid),
    .in_stall  (ay_stall),
    .in_p      (ay_side.coord),
    .in_q      (ay_p),
    .in_side   (az_in_side),
    .trig      (trig[REG_ANGLE_Z]),
    .out_valid (result_valid),
    .out_stall (az_stall),
    .out_p     (az_p),
    .out_q     (az_q),
    .out_side  (az_side)
  );

  assign az_stall = result_stall;

  // last axis registers serve as the output register
  assign result.out_x      = az_q;
  assign result.out_y      = az_p;
  assign result.out_z      = az_side.coord;
  assign result.out_colour = az_side.colour;

endmodule

// ===== rtl/core/epr_checker.sv =====
// ----------------------------------------------------------------------------
// Euler point rotation port checker
// Port-level assertions, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "euler_point_rotation_macros.svh"

module epr_checker
  import epr_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  vertex_valid,
  input logic                  vertex_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input result_t               result,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [AXIS_BITS-1:0]  cfg_index
);

  localparam int CNT_BITS = $clog2(PIPE_DEPTH + 2);

  logic [CNT_BITS-1:0] inflight, inflight_next;
  logic                in_take, out_take, angle_write;

  assign in_take     = vertex_valid && !vertex_stall;
  assign out_take    = result_valid && !result_stall;
  assign angle_write = cfg_valid && cfg_ready &&
                       (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
                        cfg_index == REG_ANGLE_Z);

  always_comb begin
    inflight_next = inflight + CNT_BITS'(in_take) - CNT_BITS'(out_take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `EPR_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
  `EPR_ASSERT_NEVER(a_result_invented, result_valid && inflight == '0, "result without a vertex")
  `EPR_ASSERT(a_depth, inflight <= CNT_BITS'(PIPE_DEPTH), "more vertices held than pipe stages")
  `EPR_ASSERT(a_angle_busy, angle_write |=> !cfg_ready && vertex_stall, "angle write did not block")
  `EPR_ASSERT(a_busy_blocks, !cfg_ready |-> vertex_stall, "vertex taken while angles update")

endmodule

bind euler_point_rotation epr_checker u_epr_checker (.*);
